// ===== sv/nrf_pkg.sv =====
// Shared constants and types of the non-overlapping repeat finder.
package nrf_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int LEN_W = 6;
	localparam int GRP_W = IDX_W;
	localparam int TPOS_W = 7;
	localparam int KEY_W = LEN_W + GRP_W + TPOS_W;
	localparam int TUP_DEPTH = 2 * MAX_ENTRIES;
	localparam int TUP_AW = $clog2(TUP_DEPTH);
	localparam int NT_W = $clog2(TUP_DEPTH + 1);
	localparam int SPOS_W = 5;
	localparam int DIV_STEPS = LEN_W;
	localparam int DIV_CW = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic             valid;
		logic [SPOS_W-1:0] start;
		logic [LEN_W-1:0]  stop;
		logic [LEN_W-1:0]  count;
		logic             last;
	} nrf_push_t;

endpackage

// ===== sv/nrf_div.sv =====
// Iterative restoring divider that returns the remainder, one bit a cycle.
module nrf_div import nrf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LEN_W-1:0]  dividend,
	input  logic [SPOS_W-1:0] divisor,
	output logic              done,
	output logic [SPOS_W-1:0] remainder
);

	logic              busy_q;
	logic [DIV_CW-1:0] step_q;
	logic [LEN_W-1:0]  num_q;
	logic [SPOS_W-1:0] den_q;
	logic [SPOS_W-1:0] rem_q;
	logic              done_q;
	logic [SPOS_W:0]   trial;
	logic [SPOS_W:0]   diff;

	assign trial = {rem_q, num_q[LEN_W-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[LEN_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= diff[SPOS_W-1:0];
			end else begin
				rem_q <= trial[SPOS_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

// ===== sv/nrf_core.sv =====
// Sequencer with the entry, tuple and run stores, tuple generation and greedy scan.
module nrf_core import nrf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SPOS_W-1:0] in_pos,
	input  logic [LEN_W-1:0]  in_lcp,
	input  logic              in_last,
	input  logic [LEN_W-1:0]  min_len,
	input  logic              out_free,
	output nrf_push_t         push
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_GRD   = 4'd1;
	localparam logic [3:0] ST_GDAT  = 4'd2;
	localparam logic [3:0] ST_GDIV  = 4'd3;
	localparam logic [3:0] ST_GW1   = 4'd4;
	localparam logic [3:0] ST_GW2   = 4'd5;
	localparam logic [3:0] ST_SINIT = 4'd6;
	localparam logic [3:0] ST_PASS  = 4'd7;
	localparam logic [3:0] ST_GRP   = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;
	localparam logic [3:0] ST_COVR  = 4'd10;
	localparam logic [3:0] ST_CHK   = 4'd11;
	localparam logic [3:0] ST_FIN   = 4'd12;
	localparam logic [3:0] ST_END   = 4'd13;

	logic [3:0] state_q;

	logic [SPOS_W+LEN_W-1:0] ent_mem [MAX_ENTRIES];
	logic [SPOS_W+LEN_W-1:0] ent_rd_q;
	logic [KEY_W-1:0]        tup_mem [TUP_DEPTH];
	logic [KEY_W-1:0]        tup_rd_q;
	logic [SPOS_W-1:0]       rs_mem [MAX_ENTRIES];
	logic [SPOS_W-1:0]       rs_rd_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  le_q;
	logic [CNT_W-1:0]  gi_q;
	logic [SPOS_W-1:0] prev_s_q;
	logic [LEN_W-1:0]  prev_l_q;
	logic [LEN_W-1:0]  len_q;
	logic [TPOS_W-1:0] p1_q;
	logic [TPOS_W-1:0] p2_q;
	logic [SPOS_W-1:0] lo_q;
	logic [LEN_W-1:0]  dvd_q;
	logic [LEN_W-1:0]  pre_l_q;
	logic [GRP_W-1:0]  grp_q;
	logic [NT_W-1:0]   nt_q;

	logic [NT_W-1:0]   ra_q;
	logic              dv_q;
	logic [KEY_W-1:0]  best_q;
	logic              found_q;
	logic [KEY_W-1:0]  prev_key_q;
	logic              have_prev_q;
	logic [GRP_W-1:0]  grp_pre_q;
	logic [TPOS_W-1:0] next_k_q;
	logic [CNT_W-1:0]  nrun_q;
	logic [LEN_W-1:0]  run_len_q;
	logic [SPOS_W-1:0] first_q;
	logic [MAX_ENTRIES-1:0] cov_q;
	logic [CNT_W-1:0]  cj_q;
	logic              cdv_q;
	logic              fin_q;
	nrf_push_t         pend_q;
	nrf_push_t         push_q;
	nrf_push_t         push_d;

	logic              div_start;
	logic              div_done;
	logic [SPOS_W-1:0] div_rem;

	logic [SPOS_W-1:0] rd_s;
	logic [LEN_W-1:0]  rd_l;
	logic [TPOS_W-1:0] sum1;
	logic [TPOS_W-1:0] sum2;
	logic              nonov;
	logic [SPOS_W-1:0] pos_gap;
	logic [TPOS_W-1:0] half;
	logic [GRP_W-1:0]  grp_n;
	logic [LEN_W-1:0]  l3;
	logic              cand;
	logic [LEN_W-1:0]  b_len;
	logic [GRP_W-1:0]  b_grp;
	logic [TPOS_W-1:0] b_k;
	logic [TPOS_W:0]   kend;
	logic [IDX_W-1:0]  kend_idx;
	logic              accept;
	logic [MAX_ENTRIES-1:0] lmask;
	nrf_push_t         newres;

	assign rd_s = ent_rd_q[SPOS_W+LEN_W-1:LEN_W];
	assign rd_l = ent_rd_q[LEN_W-1:0];
	assign sum1 = TPOS_W'(prev_s_q) + TPOS_W'(prev_l_q);
	assign sum2 = TPOS_W'(rd_s) + TPOS_W'(prev_l_q);
	assign nonov = (TPOS_W'(rd_s) >= sum1) || (sum2 <= TPOS_W'(prev_s_q));
	assign pos_gap = (prev_s_q < rd_s) ? rd_s - prev_s_q : prev_s_q - rd_s;
	assign half = (TPOS_W'(prev_l_q) + TPOS_W'(pos_gap)) >> 1;
	assign grp_n = grp_q + GRP_W'(pre_l_q != len_q);
	assign l3 = dvd_q - LEN_W'(div_rem);
	assign div_start = (state_q == ST_GDAT) && (gi_q != '0) && !nonov
		&& (prev_s_q != rd_s);

	assign cand = (!have_prev_q || tup_rd_q > prev_key_q) && (!found_q || tup_rd_q < best_q);

	assign b_len = ~best_q[KEY_W-1:GRP_W+TPOS_W];
	assign b_grp = best_q[GRP_W+TPOS_W-1:TPOS_W];
	assign b_k = best_q[TPOS_W-1:0];
	assign kend = (TPOS_W+1)'(b_k) + (TPOS_W+1)'(b_len);
	assign kend_idx = IDX_W'(kend - 1'b1);
	assign accept = (b_len != '0) && (b_len >= min_len) && (b_k >= next_k_q)
		&& (b_k < TPOS_W'(le_q)) && (kend <= (TPOS_W+1)'(le_q))
		&& !cov_q[b_k[IDX_W-1:0]] && !cov_q[kend_idx]
		&& (nrun_q < CNT_W'(MAX_ENTRIES));

	assign lmask = ~({MAX_ENTRIES{1'b1}} << run_len_q);

	always_comb begin
		newres.valid = 1'b1;
		newres.start = first_q;
		newres.stop = LEN_W'(LEN_W'(first_q) + run_len_q);
		newres.count = LEN_W'(nrun_q);
		newres.last = 1'b0;
	end

	always_comb begin
		push_d = '0;
		if (state_q == ST_EMIT && pend_q.valid && out_free) begin
			push_d = pend_q;
		end
		if (state_q == ST_END && out_free) begin
			push_d = {1'b1, pend_q.start, pend_q.stop, pend_q.count, 1'b1};
		end
	end

	nrf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (half[LEN_W-1:0]),
		.divisor   (pos_gap),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign push = push_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && cnt_q < CNT_W'(MAX_ENTRIES)) begin
			ent_mem[cnt_q[IDX_W-1:0]] <= {in_pos, in_lcp};
		end
		if (state_q == ST_GRD) begin
			ent_rd_q <= ent_mem[gi_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_GW1) begin
			tup_mem[nt_q[TUP_AW-1:0]] <= {~len_q, grp_n, p1_q};
		end else if (state_q == ST_GW2) begin
			tup_mem[nt_q[TUP_AW-1:0]] <= {~len_q, grp_q, p2_q};
		end
		if (state_q == ST_PASS) begin
			tup_rd_q <= tup_mem[ra_q[TUP_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHK && accept) begin
			rs_mem[nrun_q[IDX_W-1:0]] <= b_k[SPOS_W-1:0];
		end
		if (state_q == ST_COVR) begin
			rs_rd_q <= rs_mem[cj_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			le_q <= '0;
			gi_q <= '0;
			nt_q <= '0;
			grp_q <= '0;
			pre_l_q <= '0;
			ra_q <= '0;
			dv_q <= 1'b0;
			found_q <= 1'b0;
			have_prev_q <= 1'b0;
			grp_pre_q <= '0;
			next_k_q <= '0;
			nrun_q <= '0;
			cov_q <= '0;
			cj_q <= '0;
			cdv_q <= 1'b0;
			fin_q <= 1'b0;
			pend_q <= '0;
			push_q <= '0;
		end else begin
			push_q <= push_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_last) begin
							le_q <= (cnt_q < CNT_W'(MAX_ENTRIES)) ? cnt_q + 1'b1 : cnt_q;
							cnt_q <= '0;
							gi_q <= '0;
							nt_q <= '0;
							grp_q <= '0;
							pre_l_q <= '0;
							state_q <= ST_GRD;
						end else if (cnt_q < CNT_W'(MAX_ENTRIES)) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_GRD: begin
					state_q <= (gi_q < le_q) ? ST_GDAT : ST_SINIT;
				end
				ST_GDAT: begin
					if (gi_q == '0) begin
						prev_s_q <= rd_s;
						prev_l_q <= rd_l;
						gi_q <= gi_q + 1'b1;
						state_q <= ST_GRD;
					end else if (nonov) begin
						len_q <= prev_l_q;
						p1_q <= TPOS_W'(prev_s_q);
						p2_q <= TPOS_W'(rd_s);
						state_q <= ST_GW1;
					end else if (prev_s_q == rd_s) begin
						prev_s_q <= rd_s;
						prev_l_q <= rd_l;
						gi_q <= gi_q + 1'b1;
						state_q <= ST_GRD;
					end else begin
						lo_q <= (prev_s_q < rd_s) ? prev_s_q : rd_s;
						dvd_q <= half[LEN_W-1:0];
						state_q <= ST_GDIV;
					end
				end
				ST_GDIV: begin
					if (div_done) begin
						len_q <= l3;
						p1_q <= TPOS_W'(lo_q);
						p2_q <= TPOS_W'(lo_q) + TPOS_W'(l3);
						state_q <= ST_GW1;
					end
				end
				ST_GW1: begin
					grp_q <= grp_n;
					nt_q <= nt_q + 1'b1;
					state_q <= ST_GW2;
				end
				ST_GW2: begin
					nt_q <= nt_q + 1'b1;
					pre_l_q <= len_q;
					prev_s_q <= rd_s;
					prev_l_q <= rd_l;
					gi_q <= gi_q + 1'b1;
					state_q <= ST_GRD;
				end
				ST_SINIT: begin
					cov_q <= '0;
					grp_pre_q <= '0;
					next_k_q <= '0;
					nrun_q <= '0;
					have_prev_q <= 1'b0;
					found_q <= 1'b0;
					ra_q <= '0;
					dv_q <= 1'b0;
					fin_q <= 1'b0;
					pend_q <= '0;
					state_q <= ST_PASS;
				end
				ST_PASS: begin
					if (ra_q < nt_q) begin
						ra_q <= ra_q + 1'b1;
						dv_q <= 1'b1;
					end else begin
						dv_q <= 1'b0;
					end
					if (dv_q && cand) begin
						best_q <= tup_rd_q;
						found_q <= 1'b1;
					end
					if (ra_q == nt_q && !dv_q) begin
						state_q <= found_q ? ST_GRP : ST_FIN;
					end
				end
				ST_GRP: begin
					if (b_grp != grp_pre_q && nrun_q >= CNT_W'(2)) begin
						state_q <= ST_EMIT;
					end else begin
						if (b_grp != grp_pre_q) begin
							nrun_q <= '0;
							next_k_q <= '0;
						end
						grp_pre_q <= b_grp;
						state_q <= ST_CHK;
					end
				end
				ST_EMIT: begin
					if (!pend_q.valid || out_free) begin
						pend_q <= newres;
						cj_q <= '0;
						cdv_q <= 1'b0;
						state_q <= fin_q ? ST_END : ST_COVR;
					end
				end
				ST_COVR: begin
					if (cj_q < nrun_q) begin
						cj_q <= cj_q + 1'b1;
						cdv_q <= 1'b1;
					end else begin
						cdv_q <= 1'b0;
					end
					if (cdv_q) begin
						cov_q <= cov_q | (lmask << rs_rd_q);
					end
					if (cj_q == nrun_q && !cdv_q) begin
						nrun_q <= '0;
						next_k_q <= '0;
						grp_pre_q <= b_grp;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (accept) begin
						if (nrun_q == '0) begin
							first_q <= b_k[SPOS_W-1:0];
						end
						nrun_q <= nrun_q + 1'b1;
						run_len_q <= b_len;
						next_k_q <= kend[TPOS_W-1:0];
					end
					prev_key_q <= best_q;
					have_prev_q <= 1'b1;
					found_q <= 1'b0;
					ra_q <= '0;
					dv_q <= 1'b0;
					state_q <= ST_PASS;
				end
				ST_FIN: begin
					fin_q <= 1'b1;
					state_q <= (nrun_q >= CNT_W'(2)) ? ST_EMIT : ST_END;
				end
				ST_END: begin
					if (out_free) begin
						pend_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/non_overlapping_repeat_finder_unit.sv =====
// Top level: stream ports, minimum-length register, output register and the sequencer.
// Each entry is stored as it is accepted; the item marked last then holds the block for up to
// 63 selection passes over the tuple store (one read a cycle), a remainder division for each
// overlapping pair with distinct starts, and the covering passes. Input is not ready meanwhile,
// and output stalls lengthen the hold.
// Reset clears control state and sets the minimum length to 1; the stores are not cleared.
module non_overlapping_repeat_finder_unit import nrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // suffix_pos[4:0], common_prefix_len[10:5], zero
	input  logic        s_axis_tlast,  // last_entry
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,     // minimum repeat length
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // repeat_start[4:0], repeat_end[10:5], repeat_count[16:11]
	output logic        m_axis_tlast   // last_result
);

	logic [LEN_W-1:0] min_len_q;
	logic             out_valid_q;
	nrf_push_t        out_q;
	nrf_push_t        push;
	logic             out_free;

	assign out_free = !push.valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= LEN_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_len_q <= cfg_wdata;
			end
			if (push.valid) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_q <= push;
		end
	end

	nrf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_pos   (s_axis_tdata[4:0]),
		.in_lcp   (s_axis_tdata[10:5]),
		.in_last  (s_axis_tlast),
		.min_len  (min_len_q),
		.out_free (out_free),
		.push     (push)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'b0, out_q.count, out_q.stop, out_q.start};
	assign m_axis_tlast = out_q.last;

endmodule
